@@ sv/ard_pkg.sv @@
// ----------------------------------------------------------------------------
// ard_pkg
// Shared constants, types and the CRC-8 byte update for the reply deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ard_pkg;

	localparam logic [7:0] SYNC_BYTE      = 8'h47;
	localparam logic [4:0] SETPOINT_BYTES = 5'd8;

	localparam int         CFG_DATA_W     = 16;
	localparam logic       REG_LONG_LAYOUT = 1'b0;
	localparam logic       REG_GEAR_RATIO  = 1'b1;
	localparam logic [15:0] GEAR_RATIO_RESET = 16'd25006;

	localparam logic signed [25:0] ANGLE_MIN = -26'sd16777216;
	localparam logic signed [25:0] ANGLE_MAX = 26'sd16777215;

	// CRC-8/Maxim contribution of each set bit of crc ^ data
	localparam logic [7:0] CRC_TERMS [8] = '{
		8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
	};

	typedef struct packed {
		logic signed [20:0] motor_count;
		logic [15:0]        joint_count;
		logic signed [21:0] motor_delta;
		logic signed [16:0] joint_delta;
		logic [31:0]        joint_product;
		logic [15:0]        drive_current;
		logic [15:0]        drive_pwm;
		logic               position_crc_ok;
		logic               drive_crc_ok;
	} ard_stage_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] x;
		logic [7:0] r;
		x = crc ^ data;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			if (x[k]) begin
				r = r ^ CRC_TERMS[k];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/ard_frame.sv @@
// ----------------------------------------------------------------------------
// ard_frame
// Sync hunt, byte slotting, running CRCs and frame assembly into stage two.
// ----------------------------------------------------------------------------
`default_nettype none

module ard_frame (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid_s1,
	input  wire logic [7:0]         byte_s1,
	input  wire logic               s2_ready,
	input  wire logic               long_layout,
	input  wire logic [15:0]        gear_ratio_q8,
	output logic                    valid_s2,
	output ard_pkg::ard_stage_t     stage_s2
);
	import ard_pkg::*;

	logic               hunting_q;
	logic [4:0]         pos_q;
	logic [7:0]         bytes_q [9];
	logic [7:0]         pos_crc_q;
	logic [7:0]         drv_crc_q;
	logic signed [20:0] prev_motor_q;
	logic [15:0]        prev_joint_q;

	logic               step;
	logic [4:0]         skip;
	logic               past_skip;
	logic [4:0]         idx;
	logic               in_pos;
	logic               in_drv;
	logic               at_crc1;
	logic               last;
	logic [7:0]         pos_crc_next;
	logic [7:0]         drv_crc_next;
	logic signed [20:0] motor;
	logic [15:0]        joint;
	ard_stage_t         stage;

	assign step      = valid_s1 && s2_ready;
	assign skip      = long_layout ? SETPOINT_BYTES : 5'd0;
	assign past_skip = pos_q >= skip;
	assign idx       = pos_q - skip;
	assign in_pos    = past_skip && (idx < 5'd5);
	assign in_drv    = past_skip && (idx >= 5'd5) && (idx < 5'd9);
	assign at_crc1   = past_skip && (idx == 5'd9);
	assign last      = past_skip && (idx >= 5'd10);

	assign pos_crc_next = crc8_update(pos_crc_q, byte_s1);
	assign drv_crc_next = crc8_update(drv_crc_q, byte_s1);

	assign motor = $signed({bytes_q[2][7], bytes_q[2], 12'b0})
		+ $signed({5'b0, bytes_q[0], bytes_q[1]});
	assign joint = {bytes_q[3], bytes_q[4]};

	always_comb begin
		stage.motor_count     = motor;
		stage.joint_count     = joint;
		stage.motor_delta     = {motor[20], motor} - {prev_motor_q[20], prev_motor_q};
		stage.joint_delta     = $signed({1'b0, joint} - {1'b0, prev_joint_q});
		stage.joint_product   = {16'b0, joint} * {16'b0, gear_ratio_q8};
		stage.drive_current   = {bytes_q[5], bytes_q[6]};
		stage.drive_pwm       = {bytes_q[7], bytes_q[8]};
		stage.position_crc_ok = (pos_crc_q == 8'h00);
		stage.drive_crc_ok    = (drv_crc_q == byte_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q    <= 1'b1;
			pos_q        <= '0;
			pos_crc_q    <= '0;
			drv_crc_q    <= '0;
			prev_motor_q <= '0;
			prev_joint_q <= '0;
			valid_s2     <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= step && !hunting_q && last;
			end
			if (step) begin
				if (hunting_q) begin
					if (byte_s1 == SYNC_BYTE) begin
						hunting_q <= 1'b0;
						pos_q     <= '0;
						pos_crc_q <= '0;
						drv_crc_q <= '0;
					end
				end else begin
					pos_q <= last ? 5'd0 : pos_q + 5'd1;
					if (in_pos) begin
						pos_crc_q <= pos_crc_next;
					end else if (in_drv) begin
						drv_crc_q <= drv_crc_next;
					end else if (at_crc1) begin
						pos_crc_q <= pos_crc_q ^ byte_s1;
					end else if (last) begin
						hunting_q    <= 1'b1;
						prev_motor_q <= motor;
						prev_joint_q <= joint;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !hunting_q && (in_pos || in_drv)) begin
			bytes_q[idx[3:0]] <= byte_s1;
		end
		if (step && !hunting_q && last) begin
			stage_s2 <= stage;
		end
	end

endmodule

`default_nettype wire

@@ sv/ard_angle.sv @@
// ----------------------------------------------------------------------------
// ard_angle
// Gear angle difference with floor shift and clamp, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ard_angle (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s2,
	input  wire ard_pkg::ard_stage_t stage_s2,
	output logic                     s2_ready,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output logic signed [20:0]       motor_count,
	output logic [15:0]              joint_count,
	output logic signed [21:0]       motor_delta,
	output logic signed [16:0]       joint_delta,
	output logic signed [24:0]       angle_difference,
	output logic [15:0]              drive_current,
	output logic [15:0]              drive_pwm,
	output logic                     position_crc_ok,
	output logic                     drive_crc_ok
);
	import ard_pkg::*;

	logic [33:0]        diff;
	logic signed [25:0] ang_raw;
	logic signed [25:0] ang_sat;

	assign s2_ready = !out_valid || !out_stall;

	assign diff    = {{5{stage_s2.motor_count[20]}}, stage_s2.motor_count, 8'b0}
		- {2'b0, stage_s2.joint_product};
	assign ang_raw = $signed(diff[33:8]);

	always_comb begin
		ang_sat = ang_raw;
		if (ang_raw < ANGLE_MIN) begin
			ang_sat = ANGLE_MIN;
		end else if (ang_raw > ANGLE_MAX) begin
			ang_sat = ANGLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_ready) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && s2_ready) begin
			motor_count      <= stage_s2.motor_count;
			joint_count      <= stage_s2.joint_count;
			motor_delta      <= stage_s2.motor_delta;
			joint_delta      <= stage_s2.joint_delta;
			angle_difference <= ang_sat[24:0];
			drive_current    <= stage_s2.drive_current;
			drive_pwm        <= stage_s2.drive_pwm;
			position_crc_ok  <= stage_s2.position_crc_ok;
			drive_crc_ok     <= stage_s2.drive_crc_ok;
		end
	end

endmodule

`default_nettype wire

@@ sv/actuator_reply_deframer_core.sv @@
// ----------------------------------------------------------------------------
// actuator_reply_deframer_core
// Actuator reply deframer: sync hunt, CRC-8 checks, position and angle result.
//
//   channel  | signals                        | item
//   ---------+--------------------------------+------------------------------
//   in       | in_valid, in_stall, rx_byte    | one received byte
//   out      | out_valid, out_stall, fields   | one decoded frame
//   cfg      | cfg_wr_en, cfg_index, cfg_data | register write, no read-back
//
// One byte is taken every cycle while in_stall is low; the CRCs and byte slotting
// update in a single pass after the input register. After its last byte is taken,
// a frame result passes the input register, frame/multiply stage, result register.
// Reset clears control state only; frame byte storage is written before use.
// A stall on the output holds the result and backs up to in_stall at once.
// ----------------------------------------------------------------------------
`default_nettype none

module actuator_reply_deframer_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          rx_byte,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [20:0]       motor_count,
	output logic [15:0]              joint_count,
	output logic signed [21:0]       motor_delta,
	output logic signed [16:0]       joint_delta,
	output logic signed [24:0]       angle_difference,
	output logic [15:0]              drive_current,
	output logic [15:0]              drive_pwm,
	output logic                     position_crc_ok,
	output logic                     drive_crc_ok,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_index,
	input  wire logic [ard_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ard_pkg::*;

	logic       long_layout_q;
	logic [15:0] gear_ratio_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	ard_stage_t stage_s2;
	logic       s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_layout_q <= 1'b0;
			gear_ratio_q  <= GEAR_RATIO_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LONG_LAYOUT: long_layout_q <= cfg_data[0];
				REG_GEAR_RATIO:  gear_ratio_q  <= cfg_data[15:0];
				default:         long_layout_q <= long_layout_q;
			endcase
		end
	end

	assign in_stall = valid_s1 && !s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	ard_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1),
		.s2_ready      (s2_ready),
		.long_layout   (long_layout_q),
		.gear_ratio_q8 (gear_ratio_q),
		.valid_s2      (valid_s2),
		.stage_s2      (stage_s2)
	);

	ard_angle u_angle (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s2         (valid_s2),
		.stage_s2         (stage_s2),
		.s2_ready         (s2_ready),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.motor_count      (motor_count),
		.joint_count      (joint_count),
		.motor_delta      (motor_delta),
		.joint_delta      (joint_delta),
		.angle_difference (angle_difference),
		.drive_current    (drive_current),
		.drive_pwm        (drive_pwm),
		.position_crc_ok  (position_crc_ok),
		.drive_crc_ok     (drive_crc_ok)
	);

`ifndef NO_ASSERTIONS
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no byte held");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s2_ready |=> valid_s2 && $stable(stage_s2))
		else $error("frame stage lost or changed while blocked");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s2))
		else $error("result appeared without a frame behind it");
`endif

endmodule

`default_nettype wire
